// ===== rtl/core/mpid_pkg.sv =====
package mpid_pkg;

	localparam int unsigned ACC_W = 64;
	localparam int unsigned OPB_W = 32;

	localparam logic [63:0] PI_Q16     = 64'd205887;
	localparam logic [31:0] TWO_PI_Q24 = 32'd105414358;
	localparam logic [31:0] STALL_MS   = 32'd1000;
	localparam logic [31:0] MS_PER_S   = 32'd1000;
	localparam logic [31:0] US_PER_S   = 32'd1000000;
	localparam logic [63:0] HALF_US    = 64'd500000;

	typedef enum logic [2:0] {
		CFG_KP    = 3'd0,
		CFG_KI    = 3'd1,
		CFG_KD    = 3'd2,
		CFG_SFEG  = 3'd3,
		CFG_TICK  = 3'd4,
		CFG_ILIM  = 3'd5,
		CFG_DLIM  = 3'd6,
		CFG_VOLTS = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_POS,
		ST_DIV_POS,
		ST_MUL_DT,
		ST_DIV_DT,
		ST_MUL_VC,
		ST_MUL_IT,
		ST_DIV_IT,
		ST_MUL_KP,
		ST_MUL_KD,
		ST_MUL_KI,
		ST_DIV_DUTY,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] a;
		logic [OPB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] num;
		logic [OPB_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [ACC_W-1:0] res;
	} unit_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	// Round a Q16.16 product magnitude to nearest, then apply the sign.
	function automatic logic signed [63:0] rnd_q16(input logic [63:0] p, input logic neg);
		logic [63:0] r;
		r = (p + 64'd32768) >> 16;
		return neg ? -$signed(r) : $signed(r);
	endfunction

endpackage

// ===== rtl/core/mpid_mul.sv =====
module mpid_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpid_pkg::mul_req_t   req,
	output mpid_pkg::unit_rsp_t  rsp
);

	logic [mpid_pkg::ACC_W-1:0] a_q;
	logic [mpid_pkg::ACC_W-1:0] acc_q;
	logic [mpid_pkg::OPB_W-1:0] b_q;
	logic [$clog2(mpid_pkg::OPB_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	// One multiplier bit per cycle; the product fits 64 bits, so bits shifted
	// out of the top of a_q never matter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $bits(cnt_q)'(mpid_pkg::OPB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[mpid_pkg::ACC_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[mpid_pkg::OPB_W-1:1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = acc_q;

endmodule

// ===== rtl/core/mpid_div.sv =====
module mpid_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpid_pkg::div_req_t   req,
	output mpid_pkg::unit_rsp_t  rsp
);

	logic [mpid_pkg::ACC_W-1:0] nq_q;
	logic [mpid_pkg::OPB_W-1:0] den_q;
	logic [mpid_pkg::OPB_W-1:0] rem_q;
	logic [$clog2(mpid_pkg::ACC_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [mpid_pkg::OPB_W:0] trial;
	logic [mpid_pkg::OPB_W:0] diff;
	logic ge;

	// Restoring division: one quotient bit per cycle. The dividend shifts out
	// of nq_q at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, nq_q[mpid_pkg::ACC_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $bits(cnt_q)'(mpid_pkg::ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			nq_q  <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mpid_pkg::OPB_W-1:0] : trial[mpid_pkg::OPB_W-1:0];
			nq_q  <= {nq_q[mpid_pkg::ACC_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = nq_q;

endmodule

// ===== rtl/core/motor_position_pid_with_speed_estimate.sv =====
// Input beats are taken only in ST_IDLE; a new beat waits until the last is through.
// Each beat runs seven serial multiplies and four serial divides one after another
// on two shared units, then waits in ST_PUSH until its result can be handed over.
// The next input beat is taken while the previous result waits at the output.
// Reset (arst_n low, asynchronous) clears control state and loads register defaults.
module motor_position_pid_with_speed_estimate #(
	parameter int unsigned COUNTS_PER_TURN = 72
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] encoder_count,
	input  logic [31:0]        time_ms,
	input  logic signed [31:0] position_target,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] duty,
	output logic signed [31:0] velocity_command
);

	mpid_pkg::state_t state_q, state_d;
	mpid_pkg::mul_req_t mul_req;
	mpid_pkg::div_req_t div_req;
	mpid_pkg::unit_rsp_t mul_rsp, div_rsp;

	logic signed [31:0] kp_q, ki_q, kd_q, sfeg_q;
	logic [19:0] tick_q;
	logic [30:0] ilim_q;
	logic [14:0] dlim_q;
	logic [5:0]  volts_q;

	logic signed [31:0] enc_q, tgt_q, pos_q;
	logic [31:0] now_q;
	logic signed [31:0] anchor_pos_q, speed_q, held_q, ei_q;
	logic [31:0] anchor_time_q;
	logic signed [63:0] vref_q;
	logic signed [15:0] duty_q;
	logic signed [15:0] duty_out_q;
	logic signed [31:0] vel_out_q;
	logic out_valid_q;

	logic signed [31:0] err, verr;
	logic [31:0] err_mag, elapsed;
	logic signed [63:0] dth;
	logic [63:0] dth_mag, vref_mag;
	logic big_move, push;

	mpid_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	mpid_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			sfeg_q  <= '0;
			tick_q  <= 20'd1000;
			ilim_q  <= 31'd65536;
			dlim_q  <= 15'd29491;
			volts_q <= 6'd12;
		end else if (cfg_we) begin
			case (mpid_pkg::cfg_idx_t'(cfg_index))
				mpid_pkg::CFG_KP:    kp_q    <= cfg_data;
				mpid_pkg::CFG_KI:    ki_q    <= cfg_data;
				mpid_pkg::CFG_KD:    kd_q    <= cfg_data;
				mpid_pkg::CFG_SFEG:  sfeg_q  <= cfg_data;
				mpid_pkg::CFG_TICK:  tick_q  <= cfg_data[19:0];
				mpid_pkg::CFG_ILIM:  ilim_q  <= cfg_data[30:0];
				mpid_pkg::CFG_DLIM:  dlim_q  <= cfg_data[14:0];
				mpid_pkg::CFG_VOLTS: volts_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign err      = mpid_pkg::sat32(64'(tgt_q) - 64'(pos_q));
	assign err_mag  = mpid_pkg::mag32(err);
	assign dth      = 64'(pos_q) - 64'(anchor_pos_q);
	assign dth_mag  = dth[63] ? -dth : dth;
	assign big_move = dth_mag > mpid_pkg::PI_Q16;
	assign elapsed  = now_q - anchor_time_q;
	assign verr     = mpid_pkg::sat32(64'(held_q) - 64'(speed_q));
	assign vref_mag = vref_q[63] ? 64'(-vref_q) : 64'(vref_q);
	assign push     = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mpid_pkg::ST_IDLE:     if (in_valid) state_d = mpid_pkg::ST_MUL_POS;
			mpid_pkg::ST_MUL_POS:  if (mul_rsp.done) state_d = mpid_pkg::ST_DIV_POS;
			mpid_pkg::ST_DIV_POS:  if (div_rsp.done) state_d = mpid_pkg::ST_MUL_DT;
			mpid_pkg::ST_MUL_DT:   if (mul_rsp.done) state_d = mpid_pkg::ST_DIV_DT;
			mpid_pkg::ST_DIV_DT:   if (div_rsp.done) state_d = mpid_pkg::ST_MUL_VC;
			mpid_pkg::ST_MUL_VC:   if (mul_rsp.done) state_d = mpid_pkg::ST_MUL_IT;
			mpid_pkg::ST_MUL_IT:   if (mul_rsp.done) state_d = mpid_pkg::ST_DIV_IT;
			mpid_pkg::ST_DIV_IT:   if (div_rsp.done) state_d = mpid_pkg::ST_MUL_KP;
			mpid_pkg::ST_MUL_KP:   if (mul_rsp.done) state_d = mpid_pkg::ST_MUL_KD;
			mpid_pkg::ST_MUL_KD:   if (mul_rsp.done) state_d = mpid_pkg::ST_MUL_KI;
			mpid_pkg::ST_MUL_KI:   if (mul_rsp.done) state_d = mpid_pkg::ST_DIV_DUTY;
			mpid_pkg::ST_DIV_DUTY: if (div_rsp.done) state_d = mpid_pkg::ST_PUSH;
			mpid_pkg::ST_PUSH:     if (push) state_d = mpid_pkg::ST_IDLE;
			default:               state_d = mpid_pkg::ST_IDLE;
		endcase
	end

	// A unit is started in the first cycle of its state and reports done once.
	always_comb begin
		in_ready    = 1'b0;
		mul_req     = '0;
		div_req     = '0;
		case (state_q)
			mpid_pkg::ST_IDLE: in_ready = 1'b1;
			mpid_pkg::ST_MUL_POS: begin
				mul_req.a = 64'(mpid_pkg::mag32(enc_q));
				mul_req.b = mpid_pkg::TWO_PI_Q24;
			end
			mpid_pkg::ST_DIV_POS: begin
				div_req.num = mul_rsp.res;
				div_req.den = 32'(COUNTS_PER_TURN);
			end
			mpid_pkg::ST_MUL_DT: begin
				mul_req.a = dth_mag;
				mul_req.b = mpid_pkg::MS_PER_S;
			end
			mpid_pkg::ST_DIV_DT: begin
				div_req.num = mul_rsp.res + 64'(elapsed >> 1);
				div_req.den = elapsed;
			end
			mpid_pkg::ST_MUL_VC: begin
				mul_req.a = 64'(err_mag);
				mul_req.b = mpid_pkg::mag32(sfeg_q);
			end
			mpid_pkg::ST_MUL_IT: begin
				mul_req.a = 64'(err_mag);
				mul_req.b = 32'(tick_q);
			end
			mpid_pkg::ST_DIV_IT: begin
				div_req.num = mul_rsp.res + mpid_pkg::HALF_US;
				div_req.den = mpid_pkg::US_PER_S;
			end
			mpid_pkg::ST_MUL_KP: begin
				mul_req.a = 64'(err_mag);
				mul_req.b = mpid_pkg::mag32(kp_q);
			end
			mpid_pkg::ST_MUL_KD: begin
				mul_req.a = 64'(mpid_pkg::mag32(verr));
				mul_req.b = mpid_pkg::mag32(kd_q);
			end
			mpid_pkg::ST_MUL_KI: begin
				mul_req.a = 64'(mpid_pkg::mag32(ei_q));
				mul_req.b = mpid_pkg::mag32(ki_q);
			end
			mpid_pkg::ST_DIV_DUTY: begin
				div_req.num = vref_mag + 64'(volts_q);
				div_req.den = {25'd0, volts_q, 1'b0};
			end
			default: ;
		endcase
		case (state_q)
			mpid_pkg::ST_MUL_POS, mpid_pkg::ST_MUL_DT, mpid_pkg::ST_MUL_VC,
			mpid_pkg::ST_MUL_IT, mpid_pkg::ST_MUL_KP, mpid_pkg::ST_MUL_KD,
			mpid_pkg::ST_MUL_KI:
				mul_req.start = !mul_rsp.busy && !mul_rsp.done;
			mpid_pkg::ST_DIV_POS, mpid_pkg::ST_DIV_DT, mpid_pkg::ST_DIV_IT,
			mpid_pkg::ST_DIV_DUTY:
				div_req.start = !div_rsp.busy && !div_rsp.done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= mpid_pkg::ST_IDLE;
			anchor_pos_q  <= '0;
			anchor_time_q <= '0;
			speed_q       <= '0;
			held_q        <= '0;
			ei_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mpid_pkg::ST_DIV_DT && div_rsp.done) begin
				if (big_move) begin
					if (elapsed == '0) begin
						speed_q <= dth[63] ? 32'sh80000000 : 32'sh7fffffff;
					end else begin
						speed_q <= mpid_pkg::sat32(dth[63] ? -$signed(div_rsp.res)
							: $signed(div_rsp.res));
					end
					anchor_pos_q  <= pos_q;
					anchor_time_q <= now_q;
				end else if (elapsed > mpid_pkg::STALL_MS) begin
					speed_q       <= '0;
					anchor_pos_q  <= pos_q;
					anchor_time_q <= now_q;
				end
			end
			if (state_q == mpid_pkg::ST_MUL_VC && mul_rsp.done
				&& 64'(err_mag) < mpid_pkg::PI_Q16) begin
				held_q <= mpid_pkg::sat32(mpid_pkg::rnd_q16(mul_rsp.res,
					err[31] ^ sfeg_q[31]));
			end
			if (state_q == mpid_pkg::ST_DIV_IT && div_rsp.done) begin
				if (64'(ei_q) + (err[31] ? -$signed(div_rsp.res) : $signed(div_rsp.res))
					> $signed(64'(ilim_q))) begin
					ei_q <= $signed({1'b0, ilim_q});
				end else if (64'(ei_q) + (err[31] ? -$signed(div_rsp.res)
					: $signed(div_rsp.res)) < -$signed(64'(ilim_q))) begin
					ei_q <= -$signed({1'b0, ilim_q});
				end else begin
					ei_q <= 32'(64'(ei_q) + (err[31] ? -$signed(div_rsp.res)
						: $signed(div_rsp.res)));
				end
			end
			if (state_q == mpid_pkg::ST_PUSH && push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mpid_pkg::ST_IDLE && in_valid) begin
			enc_q <= encoder_count;
			now_q <= time_ms;
			tgt_q <= position_target;
		end
		// Angle is rounded from Q24 to Q16; its sign is the opposite of the encoder count's.
		if (state_q == mpid_pkg::ST_DIV_POS && div_rsp.done) begin
			pos_q <= enc_q[31] ? mpid_pkg::sat32($signed((div_rsp.res + 64'd128) >> 8))
				: mpid_pkg::sat32(-$signed((div_rsp.res + 64'd128) >> 8));
		end
		if (mul_rsp.done) begin
			case (state_q)
				mpid_pkg::ST_MUL_KP:
					vref_q <= mpid_pkg::rnd_q16(mul_rsp.res, err[31] ^ kp_q[31]);
				mpid_pkg::ST_MUL_KD:
					vref_q <= vref_q + mpid_pkg::rnd_q16(mul_rsp.res, verr[31] ^ kd_q[31]);
				mpid_pkg::ST_MUL_KI:
					vref_q <= vref_q + mpid_pkg::rnd_q16(mul_rsp.res, ei_q[31] ^ ki_q[31]);
				default: ;
			endcase
		end
		if (state_q == mpid_pkg::ST_DIV_DUTY && div_rsp.done) begin
			if (volts_q == '0) begin
				duty_q <= (vref_q == '0) ? 16'sd0
					: (vref_q[63] ? -$signed({1'b0, dlim_q}) : $signed({1'b0, dlim_q}));
			end else if (div_rsp.res > 64'(dlim_q)) begin
				duty_q <= vref_q[63] ? -$signed({1'b0, dlim_q}) : $signed({1'b0, dlim_q});
			end else begin
				duty_q <= vref_q[63] ? -$signed(div_rsp.res[15:0]) : $signed(div_rsp.res[15:0]);
			end
		end
		if (state_q == mpid_pkg::ST_PUSH && push) begin
			duty_out_q <= duty_q;
			vel_out_q  <= held_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign duty             = duty_out_q;
	assign velocity_command = vel_out_q;

`ifndef SYNTHESIS
	a_one_unit_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("both arithmetic units started in one cycle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == mpid_pkg::ST_MUL_POS))
		else $error("accepted beat did not start the sequence");

	a_push_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpid_pkg::ST_PUSH && out_valid && !out_ready)
		|=> (state_q == mpid_pkg::ST_PUSH))
		else $error("result left while the output beat was still pending");

	a_integral_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpid_pkg::ST_DIV_IT && div_rsp.done)
		|=> (64'(ei_q) <= $signed(64'(ilim_q)) && 64'(ei_q) >= -$signed(64'(ilim_q))))
		else $error("error integral outside its limit");
`endif

endmodule
